// ===== rtl/core/sct_pkg.sv =====
// Shared types, constants and helpers for the source character tokenizer.
`timescale 1ns / 1ps

package sct_pkg;

   localparam int DEPTH_BITS = 8;
   localparam int POS_BITS   = 16;

   localparam logic [2:0] MODE_NAME  = 3'd0;
   localparam logic [2:0] MODE_PARAM = 3'd1;
   localparam logic [2:0] MODE_ARROW = 3'd2;
   localparam logic [2:0] MODE_DECL  = 3'd3;
   localparam logic [2:0] MODE_EXPR  = 3'd4;
   localparam logic [2:0] MODE_IDLE  = 3'd5;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   typedef struct packed {
      logic [2:0]            mode;
      logic [DEPTH_BITS-1:0] depth;
      logic [7:0]            prev;
      logic [POS_BITS-1:0]   line;
      logic [POS_BITS-1:0]   column;
      logic                  err;
   } sct_state_type;

   typedef struct packed {
      logic        append_valid;
      logic [7:0]  append_char;
      logic        token_end;
      logic [2:0]  token_kind;
      logic        error_flag;
      logic [15:0] error_line;
      logic [15:0] error_column;
   } sct_result_type;

   function automatic logic sct_is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c inside {[8'd9:8'd13]});
   endfunction

   function automatic logic sct_is_letter(input logic [7:0] c);
      return (c inside {[8'd65:8'd90], [8'd97:8'd122]}) || (c == 8'd95);
   endfunction

   // Saturate a position counter to the 16-bit report width.
   function automatic logic [15:0] sct_clamp_pos(input logic [POS_BITS-1:0] v);
      logic [POS_BITS+15:0] w;
      w = {16'd0, v};
      if (w > (POS_BITS+16)'(17'h0FFFF)) begin
         return 16'hFFFF;
      end
      return w[15:0];
   endfunction

endpackage

// ===== rtl/core/sct_if.sv =====
// Valid/ready channel interfaces for tokenizer requests and responses.
`timescale 1ns / 1ps

interface sct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface sct_rsp_if;
   logic        valid;
   logic        ready;
   logic        append_valid;
   logic [7:0]  append_char;
   logic        token_end;
   logic [2:0]  token_kind;
   logic        error_flag;
   logic [15:0] error_line;
   logic [15:0] error_column;

   modport source (output valid, output append_valid, output append_char,
                   output token_end, output token_kind, output error_flag,
                   output error_line, output error_column, input ready);
   modport sink (input valid, input append_valid, input append_char,
                 input token_end, input token_kind, input error_flag,
                 input error_line, input error_column, output ready);
endinterface

// ===== rtl/core/sct_step.sv =====
// Combinational tokenizer step: next state and result for one byte.
`timescale 1ns / 1ps

module sct_step (
   input  sct_pkg::sct_state_type  cur,
   input  logic [7:0]              char_in,
   output sct_pkg::sct_state_type  nxt,
   output sct_pkg::sct_result_type res
);
   import sct_pkg::*;

   logic [2:0] mode;
   logic       in_expr;
   logic       app;
   logic [7:0] ach;
   logic       tend;
   logic [2:0] kind;
   logic       bad;
   logic       prev_space;

   always_comb begin
      nxt        = cur;
      app        = 1'b0;
      ach        = 8'd0;
      tend       = 1'b0;
      kind       = 3'd0;
      bad        = 1'b0;
      mode       = (cur.mode > MODE_IDLE) ? MODE_IDLE : cur.mode;
      in_expr    = (mode == MODE_DECL) || (mode == MODE_EXPR);
      prev_space = sct_is_space(cur.prev);

      if (!cur.err) begin
         if (sct_is_space(char_in)) begin
            if (!prev_space) begin
               case (mode)
                  MODE_NAME: begin
                     tend = 1'b1; kind = MODE_NAME; mode = MODE_PARAM;
                  end
                  MODE_PARAM: begin
                     tend = 1'b1; kind = MODE_PARAM;
                  end
                  MODE_ARROW: begin
                     if (cur.prev != CHAR_GT) begin
                        bad = 1'b1;
                     end else begin
                        tend = 1'b1; kind = MODE_ARROW; mode = MODE_DECL;
                     end
                  end
                  MODE_DECL, MODE_EXPR: begin
                     app = 1'b1; ach = CHAR_SPACE;
                  end
                  default: ;
               endcase
            end
         end else if (char_in == CHAR_LPAREN) begin
            if (mode == MODE_ARROW) begin
               mode = MODE_DECL; app = 1'b1; ach = char_in;
               nxt.depth = DEPTH_BITS'(1);
            end else if (in_expr) begin
               if (cur.depth != '1) nxt.depth = cur.depth + 1'b1;
               app = 1'b1; ach = char_in;
            end else if (mode == MODE_IDLE) begin
               app = 1'b1; ach = char_in; mode = MODE_EXPR;
               nxt.depth = DEPTH_BITS'(1);
            end
         end else if (char_in == CHAR_RPAREN) begin
            if (mode == MODE_NAME || mode == MODE_PARAM) begin
               app = 1'b1; ach = char_in;
            end else if (in_expr) begin
               if (cur.depth != '0) nxt.depth = cur.depth - 1'b1;
               app = 1'b1; ach = char_in;
               if (nxt.depth == '0) begin
                  tend = 1'b1; kind = mode; mode = MODE_IDLE;
               end
            end else if (mode == MODE_IDLE) begin
               mode = MODE_NAME; app = 1'b1; ach = char_in;
            end
         end else if (sct_is_letter(char_in)) begin
            if (mode == MODE_ARROW) begin
               bad = 1'b1;
            end else begin
               if (mode == MODE_IDLE) mode = MODE_NAME;
               app = 1'b1; ach = char_in;
            end
         end else if (char_in == CHAR_EQUAL) begin
            if (mode == MODE_PARAM) begin
               if (!prev_space) begin
                  bad = 1'b1;
               end else begin
                  app = 1'b1; ach = char_in; mode = MODE_ARROW;
               end
            end else if (in_expr) begin
               app = 1'b1; ach = char_in;
            end else begin
               bad = 1'b1;
            end
         end else if (char_in == CHAR_GT) begin
            if (mode == MODE_ARROW) begin
               if (cur.prev != CHAR_EQUAL) begin
                  bad = 1'b1;
               end else begin
                  app = 1'b1; ach = char_in;
               end
            end else if (mode == MODE_PARAM) begin
               bad = 1'b1;
            end else if (in_expr) begin
               app = 1'b1; ach = char_in;
            end
         end else begin
            if (in_expr) begin
               app = 1'b1; ach = char_in;
            end else begin
               bad = 1'b1;
            end
         end

         if (bad) begin
            nxt.err = 1'b1;
            app     = 1'b0;
            ach     = 8'd0;
            tend    = 1'b0;
            kind    = 3'd0;
         end else begin
            nxt.mode = mode;
            nxt.prev = char_in;
            if (char_in == CHAR_LF) begin
               if (cur.line != '1) nxt.line = cur.line + 1'b1;
               nxt.column = POS_BITS'(1);
            end else if (cur.column != '1) begin
               nxt.column = cur.column + 1'b1;
            end
         end
      end

      res.append_valid = app;
      res.append_char  = ach;
      res.token_end    = tend;
      res.token_kind   = kind;
      res.error_flag   = nxt.err;
      res.error_line   = nxt.err ? sct_clamp_pos(nxt.line) : 16'd0;
      res.error_column = nxt.err ? sct_clamp_pos(nxt.column) : 16'd0;
   end

endmodule

// ===== rtl/core/source_char_tokenizer_core.sv =====
// Top level of the streaming source character tokenizer.
`timescale 1ns / 1ps
// The response for a byte is registered and valid in the cycle after its transaction.
// Throughput: one byte per cycle while the response channel is ready; the response
// register is refilled in the same cycle it is drained.
// Reset: synchronous, active high; idle mode, depth 0, line and column 1,
// error cleared, response register empty.

module source_char_tokenizer_core (
   input logic         clock,
   input logic         reset,
   sct_req_if.sink     req_chan,
   sct_rsp_if.source   rsp_chan
);
   import sct_pkg::*;

   sct_state_type  state_ff;
   sct_state_type  state_in;
   sct_result_type result_ff;
   sct_result_type result_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           req_take;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   sct_step u_step (
      .cur     (state_ff),
      .char_in (req_chan.char_in),
      .nxt     (state_in),
      .res     (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode   <= MODE_IDLE;
         state_ff.depth  <= '0;
         state_ff.prev   <= 8'd0;
         state_ff.line   <= POS_BITS'(1);
         state_ff.column <= POS_BITS'(1);
         state_ff.err    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.append_valid = result_ff.append_valid;
   assign rsp_chan.append_char  = result_ff.append_char;
   assign rsp_chan.token_end    = result_ff.token_end;
   assign rsp_chan.token_kind   = result_ff.token_kind;
   assign rsp_chan.error_flag   = result_ff.error_flag;
   assign rsp_chan.error_line   = result_ff.error_line;
   assign rsp_chan.error_column = result_ff.error_column;

endmodule
